FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, masked while rst_n is low.
`define SCM_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk, live through reset as well.
`define SCM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/scm_pkg.sv
// Package for the signal conflict monitor: colour codes, violation kinds,
// snapshot and result types. No dependencies.
`timescale 1ns / 1ps

package scm_pkg;

  localparam int unsigned NUM_DIRS      = 4;
  localparam int unsigned COLOUR_W      = 2;
  localparam int unsigned HB_W          = 16;
  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned OUT_TDATA_W   = 8;
  localparam logic [HB_W-1:0] HB_PERIOD_RESET = 16'd60;

  typedef logic [COLOUR_W-1:0] colour_t;
  localparam colour_t COL_RED    = 2'd0;
  localparam colour_t COL_YELLOW = 2'd1;
  localparam colour_t COL_GREEN  = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE          = 3'd0,
    KIND_STRAIGHT      = 3'd1,
    KIND_ARROWS        = 3'd2,
    KIND_NS_ARROW_EW   = 3'd3,
    KIND_EW_ARROW_NS   = 3'd4,
    KIND_WALK          = 3'd5,
    KIND_STRAIGHT_SKIP = 3'd6,
    KIND_ARROW_SKIP    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_SOUTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef struct packed {
    logic                     walk;
    logic [NUM_DIRS-1:0][1:0] arrow;     // index 0 north .. 3 west
    logic [NUM_DIRS-1:0][1:0] straight;
  } snapshot_t;

  // violation lands in bit 0 when packed
  typedef struct packed {
    logic  heartbeat;
    dir_t  direction;
    kind_t kind;
    logic  violation;
  } result_t;

  function automatic logic is_green(input colour_t c);
    return c == COL_GREEN;
  endfunction

  function automatic logic is_red(input colour_t c);
    return c == COL_RED;
  endfunction

endpackage

FILE: design/scm_input_stage.sv
// Input register of the conflict monitor: unpacks and holds one snapshot.
// Depends on scm_pkg.
`timescale 1ns / 1ps

module scm_input_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           advance,
  output logic                           s1_valid,
  output scm_pkg::snapshot_t             snap
);
  import scm_pkg::*;

  logic      valid_r, valid_nxt;
  snapshot_t snap_r;

  // free when empty or when the held snapshot moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      snap_r <= in_tdata[$bits(snapshot_t)-1:0];
    end
  end

  assign s1_valid = valid_r;
  assign snap     = snap_r;

endmodule

FILE: design/scm_rule_check.sv
// Rule checks of the conflict monitor and the previous-lights register.
// Depends on scm_pkg.
`timescale 1ns / 1ps

module scm_rule_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  scm_pkg::snapshot_t snap,
  output scm_pkg::kind_t     kind,
  output scm_pkg::dir_t      direction
);
  import scm_pkg::*;

  logic [NUM_DIRS-1:0][1:0] prev_straight_r;
  logic [NUM_DIRS-1:0][1:0] prev_arrow_r;
  logic ns, ew, ns_a, ew_a;
  logic [NUM_DIRS-1:0] st_skip, ar_skip;

  always_comb begin
    ns   = is_green(snap.straight[DIR_NORTH]) || is_green(snap.straight[DIR_SOUTH]);
    ew   = is_green(snap.straight[DIR_EAST])  || is_green(snap.straight[DIR_WEST]);
    ns_a = is_green(snap.arrow[DIR_NORTH])    || is_green(snap.arrow[DIR_SOUTH]);
    ew_a = is_green(snap.arrow[DIR_EAST])     || is_green(snap.arrow[DIR_WEST]);
    for (int d = 0; d < NUM_DIRS; d++) begin
      st_skip[d] = is_green(prev_straight_r[d]) && is_red(snap.straight[d]);
      ar_skip[d] = is_green(prev_arrow_r[d])    && is_red(snap.arrow[d]);
    end
  end

  always_comb begin
    kind      = KIND_NONE;
    direction = DIR_NORTH;
    if (ns && ew) begin
      kind = KIND_STRAIGHT;
    end else if (ns_a && ew_a) begin
      kind = KIND_ARROWS;
    end else if (ns_a && ew) begin
      kind = KIND_NS_ARROW_EW;
    end else if (ew_a && ns) begin
      kind = KIND_EW_ARROW_NS;
    end else if (snap.walk && (ns || ew || ns_a || ew_a)) begin
      kind = KIND_WALK;
    end else if (st_skip != '0) begin
      kind = KIND_STRAIGHT_SKIP;
      // lowest direction wins
      for (int d = NUM_DIRS - 1; d >= 0; d--) begin
        if (st_skip[d]) begin
          direction = dir_t'(d[1:0]);
        end
      end
    end else if (ar_skip != '0) begin
      kind = KIND_ARROW_SKIP;
      for (int d = NUM_DIRS - 1; d >= 0; d--) begin
        if (ar_skip[d]) begin
          direction = dir_t'(d[1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_straight_r <= {NUM_DIRS{COL_RED}};
      prev_arrow_r    <= {NUM_DIRS{COL_RED}};
    end else if (advance) begin
      prev_straight_r <= snap.straight;
      prev_arrow_r    <= snap.arrow;
    end
  end

endmodule

FILE: design/scm_heartbeat.sv
// Heartbeat period register and check counter of the conflict monitor.
// Depends on scm_pkg.
`timescale 1ns / 1ps

module scm_heartbeat (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [scm_pkg::HB_W-1:0] cfg_wr_data,
  input  logic                     advance,
  output logic                     beat
);
  import scm_pkg::*;

  logic [HB_W-1:0] period_r;
  logic [HB_W-1:0] count_r, count_nxt;
  logic [HB_W:0]   sum;

  // a period of zero or one pulses on every check
  always_comb begin
    sum       = {1'b0, count_r} + {{HB_W{1'b0}}, 1'b1};
    beat      = sum >= {1'b0, period_r};
    count_nxt = beat ? '0 : sum[HB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= HB_PERIOD_RESET;
      count_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (advance) begin
        count_r <= count_nxt;
      end
    end
  end

endmodule

FILE: design/signal_conflict_monitor.sv
// Top level of the traffic signal conflict monitor.
// Depends on scm_pkg, scm_input_stage, scm_rule_check and scm_heartbeat.
//
//   Channel  Direction  Payload
//   in_      slave      snapshot: 8 lights (2 bits each) and walk flag
//   out_     master     violation, kind, direction, heartbeat
//   cfg_     write      heartbeat_period, 16 bits
//
// One snapshot per cycle sustained while out_tready is held high; an accepted
// snapshot passes the input register, then the result register, where
// out_tvalid rises and the out_ transaction waits to be taken.
// The checks are one short combinational pass between the two registers.
// Reset (rst_n low, synchronous) empties both registers, sets previous
// lights to red, clears the check count and restores a period of 60.
// A stalled output holds its transaction; the input register keeps
// accepting while the result register can drain or is empty.
`timescale 1ns / 1ps

module signal_conflict_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // from bit 0: north_straight[1:0], south_straight[3:2], east_straight[5:4],
  // west_straight[7:6], north_arrow[9:8], south_arrow[11:10],
  // east_arrow[13:12], west_arrow[15:14], walk_active[16], zero fill
  input  logic [scm_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // from bit 0: violation[0], violation_kind[3:1], violation_direction[5:4],
  // heartbeat[6], zero fill
  output logic [scm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [scm_pkg::HB_W-1:0]        cfg_wr_data
);
  import scm_pkg::*;

  logic      s1_valid;
  logic      advance;
  snapshot_t snap;
  kind_t     kind;
  dir_t      direction;
  logic      beat;
  logic      out_valid_r, out_valid_nxt;
  result_t   result_r, result_nxt;

  // Advance the held snapshot when the result register is empty or drains.
  assign advance = s1_valid && (!out_valid_r || out_tready);

  scm_input_stage u_input (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .snap      (snap)
  );

  // Check the rules against the previous lights; the previous lights take
  // the snapshot as it advances.
  scm_rule_check u_rules (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .snap      (snap),
    .kind      (kind),
    .direction (direction)
  );

  // Count checks and pulse every period-th one.
  scm_heartbeat u_heartbeat (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .beat        (beat)
  );

  always_comb begin
    result_nxt.violation = kind != KIND_NONE;
    result_nxt.kind      = kind;
    result_nxt.direction = direction;
    result_nxt.heartbeat = beat;

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      // drop the transaction once taken
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result while stalled; load only on advance.
  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_r};

endmodule

FILE: design/scm_checker.sv
// Port-level checker for the signal conflict monitor, bound to the top.
// Depends on scm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [scm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scm_pkg::*;

  `SCM_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `SCM_ASSERT_RST(a_flag_matches_kind, clk, rst_n, out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] != KIND_NONE)), "violation flag and kind disagree")
  `SCM_ASSERT_RST(a_dir_only_skip, clk, rst_n, (out_tvalid && out_tdata[5:4] != DIR_NORTH) |-> (out_tdata[3:1] == KIND_STRAIGHT_SKIP || out_tdata[3:1] == KIND_ARROW_SKIP), "direction set on a non-skip kind")
  `SCM_ASSERT_RST(a_out_hold, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled output changed")

endmodule

bind signal_conflict_monitor scm_checker u_scm_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for signal_conflict_monitor: streams light snapshots,
// predicts each verdict and compares it with the out_ transaction.
// Depends on scm_pkg and the design top level only.
`timescale 1ns / 1ps

module tb;
  import scm_pkg::*;

  localparam int CLK_HALF_NS  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;  // receiver hold-off used to back the block up
  localparam int SETTLE       = 6;    // margin beyond the two-stage latency
  localparam int WALK_BIT     = 16;
  localparam int ARROW_BASE   = 8;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports (every input starts at a known value)
  // ---------------------------------------------------------------------------
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [HB_W-1:0]        cfg_wr_data = '0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  signal_conflict_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Shared state between the stimulus, the driver and the monitor
  // ---------------------------------------------------------------------------
  logic [IN_TDATA_W-1:0] snapshots_pending[$];  // filled by the initial block
  result_t               verdicts_due[$];       // oldest expected verdict first
  int                    fail_count    = 0;
  bit                    gaps_on       = 1'b1;  // random idling on both sides
  bit                    long_hold_go  = 1'b0;  // ask the receiver for one long hold-off
  bit                    long_hold_done = 1'b0;
  int                    in_gap_left   = 0;
  int                    out_hold_left = 0;
  bit                    in_fire;
  bit                    in_valid_next;
  int unsigned           cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the previous lights, check count and period
  // ---------------------------------------------------------------------------
  colour_t         last_straight[NUM_DIRS];
  colour_t         last_arrow[NUM_DIRS];
  logic [HB_W-1:0] beat_count = '0;
  logic [HB_W-1:0] hb_period  = HB_PERIOD_RESET;

  initial begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      last_straight[i] = COL_RED;
      last_arrow[i]    = COL_RED;
    end
  end

  // Work out the verdict for one accepted snapshot and advance the state.
  function automatic result_t judge_snapshot(logic [IN_TDATA_W-1:0] snap);
    colour_t     st[NUM_DIRS];
    colour_t     ar[NUM_DIRS];
    logic        walk, ns_go, ew_go, ns_turn, ew_turn;
    kind_t       kind;
    dir_t        dir;
    logic [HB_W:0] count_next;
    result_t     verdict;
    for (int i = 0; i < NUM_DIRS; i++) begin
      st[i] = snap[2*i +: 2];
      ar[i] = snap[ARROW_BASE + 2*i +: 2];
    end
    walk    = snap[WALK_BIT];
    ns_go   = (st[DIR_NORTH] == COL_GREEN) || (st[DIR_SOUTH] == COL_GREEN);
    ew_go   = (st[DIR_EAST] == COL_GREEN)  || (st[DIR_WEST] == COL_GREEN);
    ns_turn = (ar[DIR_NORTH] == COL_GREEN) || (ar[DIR_SOUTH] == COL_GREEN);
    ew_turn = (ar[DIR_EAST] == COL_GREEN)  || (ar[DIR_WEST] == COL_GREEN);
    kind = KIND_NONE;
    dir  = DIR_NORTH;
    if (ns_go && ew_go) begin
      kind = KIND_STRAIGHT;
    end else if (ns_turn && ew_turn) begin
      kind = KIND_ARROWS;
    end else if (ns_turn && ew_go) begin
      kind = KIND_NS_ARROW_EW;
    end else if (ew_turn && ns_go) begin
      kind = KIND_EW_ARROW_NS;
    end else if (walk && (ns_go || ew_go || ns_turn || ew_turn)) begin
      kind = KIND_WALK;
    end else begin
      // green straight to red is checked before any arrow, lowest direction wins
      for (int i = 0; i < NUM_DIRS; i++) begin
        if (kind == KIND_NONE && last_straight[i] == COL_GREEN && st[i] == COL_RED) begin
          kind = KIND_STRAIGHT_SKIP;
          dir  = dir_t'(i);
        end
      end
      for (int i = 0; i < NUM_DIRS; i++) begin
        if (kind == KIND_NONE && last_arrow[i] == COL_GREEN && ar[i] == COL_RED) begin
          kind = KIND_ARROW_SKIP;
          dir  = dir_t'(i);
        end
      end
    end
    // a period of zero behaves as one; a lowered period pulses at once
    count_next = {1'b0, beat_count} + 1'b1;
    if (count_next >= {1'b0, hb_period}) begin
      verdict.heartbeat = 1'b1;
      beat_count        = '0;
    end else begin
      verdict.heartbeat = 1'b0;
      beat_count        = count_next[HB_W-1:0];
    end
    for (int i = 0; i < NUM_DIRS; i++) begin
      last_straight[i] = st[i];
      last_arrow[i]    = ar[i];
    end
    verdict.violation = (kind != KIND_NONE);
    verdict.kind      = kind;
    verdict.direction = dir;
    return verdict;
  endfunction

  // ---------------------------------------------------------------------------
  // Snapshot builders
  // ---------------------------------------------------------------------------
  // One light of one direction set to a colour, everything else red.
  function automatic logic [IN_TDATA_W-1:0] lamp(bit arrow, int d, colour_t c);
    logic [IN_TDATA_W-1:0] snap;
    snap = '0;
    snap[(arrow ? ARROW_BASE : 0) + 2*d +: 2] = c;
    return snap;
  endfunction

  // All eight lights in the same colour, with the walk flag given.
  function automatic logic [IN_TDATA_W-1:0] flood(colour_t c, logic walk);
    logic [IN_TDATA_W-1:0] snap;
    snap = '0;
    snap[2*2*NUM_DIRS-1:0] = {2*NUM_DIRS{c}};
    snap[WALK_BIT] = walk;
    return snap;
  endfunction

  // The picked lights of one group (N/S or E/W, straight or arrow) in one colour, rest red.
  function automatic logic [IN_TDATA_W-1:0] paint_group(bit arrow, int first_dir,
                                                         logic [1:0] pick, colour_t c);
    logic [IN_TDATA_W-1:0] snap;
    snap = '0;
    for (int k = 0; k < 2; k++) begin
      if (pick[k]) snap |= lamp(arrow, first_dir + k, c);
    end
    return snap;
  endfunction

  function automatic colour_t sparse_colour();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll <= 6) return COL_RED;
    if (roll == 7) return COL_GREEN;
    if (roll == 8) return COL_YELLOW;
    return colour_t'(2'd3);
  endfunction

  // Queue n random snapshots: mostly well-formed signal phases, some noise.
  task automatic queue_random_snapshots(int n);
    int                    added;
    int                    greens;
    int                    first_dir;
    bit                    arrow;
    logic [1:0]            pick;
    colour_t               middle;
    logic [IN_TDATA_W-1:0] snap;
    added = 0;
    while (added < n) begin
      case ($urandom_range(0, 9))
        6, 7: begin
          // raw noise, colour code three included
          snap = IN_TDATA_W'($urandom() & ((32'd1 << (WALK_BIT + 1)) - 32'd1));
          snapshots_pending.push_back(snap);
          added++;
        end
        8, 9: begin
          // mostly red with the odd lit light
          snap = '0;
          for (int i = 0; i < 2 * NUM_DIRS; i++) snap[2*i +: 2] = sparse_colour();
          snap[WALK_BIT] = ($urandom_range(0, 3) == 0);
          snapshots_pending.push_back(snap);
          added++;
        end
        default: begin
          // one phase of a signal plan: green, yellow (sometimes missed), red
          arrow     = 1'($urandom_range(0, 1));
          first_dir = 2 * int'($urandom_range(0, 1));
          pick      = 2'($urandom_range(1, 3));
          greens    = $urandom_range(1, 3);
          repeat (greens) begin
            snap = paint_group(arrow, first_dir, pick, COL_GREEN);
            snap[WALK_BIT] = ($urandom_range(0, 9) == 0);
            snapshots_pending.push_back(snap);
            added++;
          end
          case ($urandom_range(0, 7))
            0:       middle = COL_RED;
            1:       middle = colour_t'(2'd3);
            default: middle = COL_YELLOW;
          endcase
          if (middle != COL_RED) begin
            snapshots_pending.push_back(paint_group(arrow, first_dir, pick, middle));
            added++;
          end
          snap = '0;
          snap[WALK_BIT] = 1'($urandom_range(0, 1));
          snapshots_pending.push_back(snap);
          added++;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued snapshots, predict on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_gap_left = 0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) verdicts_due.push_back(judge_snapshot(in_tdata));
      // hold the current snapshot until it is taken; only then pick the next
      if (!in_tvalid || in_fire) begin
        in_valid_next = 1'b0;
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (gaps_on && snapshots_pending.size() > 0
                     && $urandom_range(0, 6) == 0) begin
          in_gap_left = $urandom_range(0, 18);  // this cycle plus the rest idles
        end else if (snapshots_pending.size() > 0) begin
          in_tdata      <= snapshots_pending.pop_front();
          in_valid_next = 1'b1;
        end
        in_tvalid <= in_valid_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every out_ transaction with the oldest expected verdict
  // ---------------------------------------------------------------------------
  task automatic check_verdict(logic [OUT_TDATA_W-1:0] raw);
    result_t got;
    result_t want;
    got = result_t'(raw[$bits(result_t)-1:0]);
    if (verdicts_due.size() == 0) begin
      $error("unexpected verdict transaction, tdata %0h", raw);
      fail_count++;
    end else begin
      want = verdicts_due.pop_front();
      if (got.violation !== want.violation) begin
        $error("violation: expected %0d, got %0d", want.violation, got.violation);
        fail_count++;
      end
      if (got.kind !== want.kind) begin
        $error("violation_kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.direction !== want.direction) begin
        $error("violation_direction: expected %0d, got %0d", want.direction, got.direction);
        fail_count++;
      end
      if (got.heartbeat !== want.heartbeat) begin
        $error("heartbeat: expected %0d, got %0d", want.heartbeat, got.heartbeat);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready    <= 1'b0;
      out_hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) check_verdict(out_tdata);
      // one long hold-off, so that the block fills up and drops in_tready
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_hold_left  = LONG_HOLD;
      end
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        out_hold_left = $urandom_range(0, 18);
        out_tready    <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  // Wait until every snapshot is taken and every verdict has come back.
  task automatic drain();
    while (snapshots_pending.size() != 0 || in_tvalid || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the period while the block is idle; the predictor follows at once.
  task automatic set_heartbeat_period(logic [HB_W-1:0] period);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hb_period = period;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset period of 60.
    // First snapshot against all-red previous lights: no skip possible.
    snapshots_pending.push_back(flood(COL_RED, 1'b0));
    // Everything green with walk: crossing straights win over all else.
    snapshots_pending.push_back(flood(COL_GREEN, 1'b1));
    // All to red: straights skip before arrows, north is lowest.
    snapshots_pending.push_back(flood(COL_RED, 1'b0));
    // Colour code three everywhere with walk: neither green nor red.
    snapshots_pending.push_back(flood(colour_t'(2'd3), 1'b1));
    snapshots_pending.push_back(flood(COL_RED, 1'b0));
    // Straight skip in each direction, and arrow skip in each direction.
    for (int d = 0; d < NUM_DIRS; d++) begin
      snapshots_pending.push_back(lamp(1'b0, d, COL_GREEN));
      snapshots_pending.push_back(flood(COL_RED, 1'b0));
    end
    for (int d = 0; d < NUM_DIRS; d++) begin
      snapshots_pending.push_back(lamp(1'b1, d, COL_GREEN));
      snapshots_pending.push_back(flood(COL_RED, 1'b0));
    end
    // Arrow conflicts: N/S arrow against E/W straight and the reverse.
    snapshots_pending.push_back(lamp(1'b1, DIR_SOUTH, COL_GREEN) | lamp(1'b0, DIR_WEST, COL_GREEN));
    snapshots_pending.push_back(lamp(1'b1, DIR_EAST, COL_GREEN) | lamp(1'b0, DIR_NORTH, COL_GREEN));
    // Crossing arrows, then walk against a lone arrow.
    snapshots_pending.push_back(lamp(1'b1, DIR_NORTH, COL_GREEN) | lamp(1'b1, DIR_WEST, COL_GREEN));
    snapshots_pending.push_back(lamp(1'b1, DIR_EAST, COL_GREEN) | IN_TDATA_W'(1 << WALK_BIT));
    // Proper green, yellow, red on west straight: no skip.
    snapshots_pending.push_back(lamp(1'b0, DIR_WEST, COL_GREEN));
    snapshots_pending.push_back(lamp(1'b0, DIR_WEST, COL_YELLOW));
    snapshots_pending.push_back(flood(COL_RED, 1'b0));
    // Enough more under the reset period to see its pulse.
    queue_random_snapshots(60);
    drain();

    // Period of one, with the receiver holding off long enough to stall input.
    set_heartbeat_period(16'd1);
    long_hold_go <= 1'b1;
    queue_random_snapshots(40);
    drain();

    // Period zero acts as one.
    set_heartbeat_period(16'd0);
    queue_random_snapshots(30);
    drain();

    set_heartbeat_period(16'hFFFF);
    queue_random_snapshots(50);
    drain();

    set_heartbeat_period(16'd2);
    queue_random_snapshots(40);
    drain();

    set_heartbeat_period(16'd13);
    queue_random_snapshots(60);
    drain();

    // Build up a count, then lower the period below it: next check pulses.
    set_heartbeat_period(16'd50);
    queue_random_snapshots(20);
    drain();
    set_heartbeat_period(16'd5);
    queue_random_snapshots(40);
    drain();

    // Last stretch at full rate on both sides.
    gaps_on = 1'b0;
    set_heartbeat_period(16'd7);
    queue_random_snapshots(60);
    drain();

    if (verdicts_due.size() != 0) begin
      $error("%0d expected verdicts never arrived", verdicts_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/scm_pkg.sv
design/scm_input_stage.sv
design/scm_rule_check.sv
design/scm_heartbeat.sv
design/signal_conflict_monitor.sv
design/scm_checker.sv
test/tb.sv
